// ===== design/bdsl_pkg.sv =====
`timescale 1ns / 1ps

package bdsl_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int THR_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] ST_RELEASED = 2'd0;
	localparam logic [1:0] ST_LEADING = 2'd1;
	localparam logic [1:0] ST_PRESSED = 2'd2;
	localparam logic [1:0] ST_TRAILING = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REJECT_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS = 2'd2;

	localparam logic PRESSED_LEVEL_RESET = 1'b0;
	localparam logic [THR_W-1:0] REJECT_RESET = 16'd20;
	localparam logic [THR_W-1:0] LONG_RESET = 16'd1000;
	localparam logic PREV_LEVEL_RESET = 1'b1;

	typedef struct packed {
		logic short_press;
		logic long_press;
		logic [1:0] button_state;
	} result_t;

endpackage

// ===== design/bdsl_step.sv =====
`timescale 1ns / 1ps

module bdsl_step #(
	parameter int COUNT_WIDTH = bdsl_pkg::COUNT_WIDTH_DEF
) (
	input  logic pin_level,
	input  logic pressed_level,
	input  logic [bdsl_pkg::THR_W-1:0] reject_ticks,
	input  logic [bdsl_pkg::THR_W-1:0] long_ticks,
	input  logic [1:0] press_state,
	input  logic previous_level,
	input  logic [COUNT_WIDTH-1:0] since_edge,
	input  logic [COUNT_WIDTH-1:0] since_leading,
	output logic [COUNT_WIDTH-1:0] next_since_edge,
	output logic [COUNT_WIDTH-1:0] next_since_leading,
	output bdsl_pkg::result_t result
);

	localparam int CMP_W = (COUNT_WIDTH > bdsl_pkg::THR_W) ? COUNT_WIDTH : bdsl_pkg::THR_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	always_comb begin
		logic [1:0] st;
		logic [COUNT_WIDTH-1:0] se;
		logic [COUNT_WIDTH-1:0] sl;
		logic shortp;
		logic longp;
		logic released_level;
		released_level = ~pressed_level;
		shortp = 1'b0;
		longp = 1'b0;
		st = press_state;
		se = (since_edge == CNT_MAX) ? CNT_MAX : since_edge + COUNT_WIDTH'(1);
		sl = (since_leading == CNT_MAX) ? CNT_MAX : since_leading + COUNT_WIDTH'(1);

		if (st == bdsl_pkg::ST_RELEASED && previous_level != pressed_level &&
				pin_level == pressed_level) begin
			st = bdsl_pkg::ST_LEADING;
			se = '0;
		end else if (st == bdsl_pkg::ST_PRESSED && previous_level != released_level &&
				pin_level == released_level) begin
			st = bdsl_pkg::ST_TRAILING;
			se = '0;
		end

		if ((st == bdsl_pkg::ST_LEADING || st == bdsl_pkg::ST_TRAILING) &&
				CMP_W'(se) > CMP_W'(reject_ticks)) begin
			if (st == bdsl_pkg::ST_LEADING) begin
				if (pin_level != pressed_level) begin
					st = bdsl_pkg::ST_RELEASED;
				end else begin
					st = bdsl_pkg::ST_PRESSED;
					sl = se;
				end
			end else begin
				if (pin_level != released_level) begin
					st = bdsl_pkg::ST_PRESSED;
				end else begin
					shortp = 1'b1;
					st = bdsl_pkg::ST_RELEASED;
				end
			end
		end

		if (st == bdsl_pkg::ST_PRESSED && CMP_W'(sl) > CMP_W'(long_ticks)) begin
			longp = 1'b1;
			st = bdsl_pkg::ST_RELEASED;
		end

		next_since_edge = se;
		next_since_leading = sl;
		result.short_press = shortp;
		result.long_press = longp;
		result.button_state = st;
	end

endmodule

// ===== design/button_debounce_short_long_press.sv =====
`timescale 1ns / 1ps

// Push-button debouncer with short and long press detection. Each request is one
// millisecond sample of the pin; it lands in an input register, passes through the
// combinational state machine logic and is registered in the result register, so
// one request is taken in every cycle while the output side keeps up. The input
// register takes a new request while a result still waits, if it is itself empty.
// Configuration writes are accepted in any cycle.
module button_debounce_short_long_press #(
	parameter int COUNT_WIDTH = bdsl_pkg::COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic pin_level,
	output logic out_valid,
	input  logic out_ready,
	output logic short_press,
	output logic long_press,
	output logic [1:0] button_state,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [bdsl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bdsl_pkg::THR_W-1:0] cfg_data
);

	logic pressed_level_q;
	logic [bdsl_pkg::THR_W-1:0] reject_ticks_q;
	logic [bdsl_pkg::THR_W-1:0] long_ticks_q;

	logic [1:0] press_state_q;
	logic previous_level_q;
	logic [COUNT_WIDTH-1:0] since_edge_q;
	logic [COUNT_WIDTH-1:0] since_leading_q;

	logic valid_s1;
	logic pin_level_s1;
	logic valid_s2;
	bdsl_pkg::result_t result_s2;

	logic advance;
	logic [COUNT_WIDTH-1:0] next_since_edge;
	logic [COUNT_WIDTH-1:0] next_since_leading;
	bdsl_pkg::result_t result;

	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	assign out_valid = valid_s2;
	assign short_press = result_s2.short_press;
	assign long_press = result_s2.long_press;
	assign button_state = result_s2.button_state;

	bdsl_step #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_step (
		.pin_level(pin_level_s1),
		.pressed_level(pressed_level_q),
		.reject_ticks(reject_ticks_q),
		.long_ticks(long_ticks_q),
		.press_state(press_state_q),
		.previous_level(previous_level_q),
		.since_edge(since_edge_q),
		.since_leading(since_leading_q),
		.next_since_edge(next_since_edge),
		.next_since_leading(next_since_leading),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_level_q <= bdsl_pkg::PRESSED_LEVEL_RESET;
			reject_ticks_q <= bdsl_pkg::REJECT_RESET;
			long_ticks_q <= bdsl_pkg::LONG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bdsl_pkg::CFG_PRESSED_LEVEL: pressed_level_q <= cfg_data[0];
				bdsl_pkg::CFG_REJECT_TICKS: reject_ticks_q <= cfg_data;
				bdsl_pkg::CFG_LONG_TICKS: long_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_state_q <= bdsl_pkg::ST_RELEASED;
			previous_level_q <= bdsl_pkg::PREV_LEVEL_RESET;
			since_edge_q <= '0;
			since_leading_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				press_state_q <= result.button_state;
				previous_level_q <= pin_level_s1;
				since_edge_q <= next_since_edge;
				since_leading_q <= next_since_leading;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pin_level_s1 <= pin_level;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

endmodule

// ===== design/bdsl_checker.sv =====
`timescale 1ns / 1ps

module bdsl_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic short_press,
	input logic long_press,
	input logic [1:0] button_state
);

	// A press ends either short or long, never both at once.
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(short_press && long_press))
		else $error("short and long press reported together");

	// Both kinds of press leave the machine released.
	a_short_released: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && short_press) |-> button_state == bdsl_pkg::ST_RELEASED)
		else $error("short press without return to released");

	a_long_released: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && long_press) |-> button_state == bdsl_pkg::ST_RELEASED)
		else $error("long press without return to released");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(short_press) &&
			$stable(long_press) && $stable(button_state)))
		else $error("stalled result changed");

endmodule

bind button_debounce_short_long_press bdsl_checker u_bdsl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.short_press(short_press),
	.long_press(long_press),
	.button_state(button_state)
);

// ===== test/button_debounce_short_long_press_tb.sv =====
`timescale 1ns / 1ps

module button_debounce_short_long_press_tb;

	localparam int CW = bdsl_pkg::COUNT_WIDTH_DEF;
	localparam int IDX_W = bdsl_pkg::CFG_IDX_W;
	localparam int TW = bdsl_pkg::THR_W;
	localparam int IDLE_PCT = 19;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam logic [IDX_W-1:0] CFG_UNMAPPED = 2'd3;
	localparam logic [TW-1:0] THR_TOP = 16'd65534;
	// Hold to a long press, bounce rejected, short press, and a release bounce
	// that falls back to pressed, with a pressed level of zero.
	localparam bit [0:18] DIRECTED = 19'b0000001010011001011;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic pin_level = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic short_press;
	logic long_press;
	logic [1:0] button_state;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = bdsl_pkg::CFG_PRESSED_LEVEL;
	logic [TW-1:0] cfg_data = '0;

	bit steady = 1'b0;
	bit hold_req = 1'b0;
	int sent_total = 0;

	class press_scoreboard;
		logic pressed_lvl;
		logic [TW-1:0] reject_thr;
		logic [TW-1:0] long_thr;
		logic [1:0] state;
		logic prev_lvl;
		logic [CW-1:0] since_edge;
		logic [CW-1:0] since_lead;
		bdsl_pkg::result_t pending_q[$];
		int errors;
		int shorts;
		int longs;

		function new();
			pressed_lvl = bdsl_pkg::PRESSED_LEVEL_RESET;
			reject_thr = bdsl_pkg::REJECT_RESET;
			long_thr = bdsl_pkg::LONG_RESET;
			state = bdsl_pkg::ST_RELEASED;
			prev_lvl = bdsl_pkg::PREV_LEVEL_RESET;
			since_edge = '0;
			since_lead = '0;
			errors = 0;
			shorts = 0;
			longs = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [TW-1:0] data);
			case (idx)
				bdsl_pkg::CFG_PRESSED_LEVEL: pressed_lvl = data[0];
				bdsl_pkg::CFG_REJECT_TICKS: reject_thr = data;
				bdsl_pkg::CFG_LONG_TICKS: long_thr = data;
				default: ;
			endcase
		endfunction

		function void note_sample(logic lvl);
			bdsl_pkg::result_t r;
			logic rel;
			r = '0;
			rel = ~pressed_lvl;
			if (since_edge != {CW{1'b1}}) since_edge++;
			if (since_lead != {CW{1'b1}}) since_lead++;
			if (state == bdsl_pkg::ST_RELEASED && prev_lvl != pressed_lvl &&
					lvl == pressed_lvl) begin
				state = bdsl_pkg::ST_LEADING;
				since_edge = '0;
			end else if (state == bdsl_pkg::ST_PRESSED && prev_lvl != rel && lvl == rel) begin
				state = bdsl_pkg::ST_TRAILING;
				since_edge = '0;
			end
			if ((state == bdsl_pkg::ST_LEADING || state == bdsl_pkg::ST_TRAILING) &&
					since_edge > reject_thr) begin
				if (state == bdsl_pkg::ST_LEADING) begin
					if (lvl != pressed_lvl) begin
						state = bdsl_pkg::ST_RELEASED;
					end else begin
						state = bdsl_pkg::ST_PRESSED;
						since_lead = since_edge;
					end
				end else if (lvl != rel) begin
					state = bdsl_pkg::ST_PRESSED;
				end else begin
					r.short_press = 1'b1;
					state = bdsl_pkg::ST_RELEASED;
				end
			end
			if (state == bdsl_pkg::ST_PRESSED && since_lead > long_thr) begin
				r.long_press = 1'b1;
				state = bdsl_pkg::ST_RELEASED;
			end
			prev_lvl = lvl;
			r.button_state = state;
			pending_q.push_back(r);
		endfunction

		function void check_result(bdsl_pkg::result_t got);
			bdsl_pkg::result_t want;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: result arrived with no request outstanding (actual %b/%b/%0d)",
					$time, got.short_press, got.long_press, got.button_state);
				return;
			end
			want = pending_q.pop_front();
			if (got.short_press != want.short_press) begin
				errors++;
				$display("%0t: short_press expected %b actual %b",
					$time, want.short_press, got.short_press);
			end
			if (got.long_press != want.long_press) begin
				errors++;
				$display("%0t: long_press expected %b actual %b",
					$time, want.long_press, got.long_press);
			end
			if (got.button_state != want.button_state) begin
				errors++;
				$display("%0t: button_state expected %0d actual %0d",
					$time, want.button_state, got.button_state);
			end
			shorts += got.short_press;
			longs += got.long_press;
		endfunction
	endclass

	press_scoreboard sb = new();

	button_debounce_short_long_press i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pin_level(pin_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.short_press(short_press),
		.long_press(long_press),
		.button_state(button_state),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	task automatic send_sample(input logic lvl);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pin_level <= lvl;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(lvl);
		sent_total++;
	endtask

	task automatic send_run(input logic lvl, input int n);
		repeat (n) send_sample(lvl);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [TW-1:0] data,
			input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		if (last) cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic pl, input logic [TW-1:0] rej,
			input logic [TW-1:0] lng);
		settle();
		write_reg(bdsl_pkg::CFG_PRESSED_LEVEL, {15'd0, pl}, 1'b0);
		write_reg(bdsl_pkg::CFG_REJECT_TICKS, rej, 1'b0);
		write_reg(bdsl_pkg::CFG_LONG_TICKS, lng, 1'b1);
	endtask

	function automatic int pick_len(input int t);
		if (t > 300) t = 300;
		case ($urandom_range(2))
			0: return $urandom_range(t + 2);
			1: return t + $urandom_range(2) - 1;
			default: return $urandom_range(2 * t + 4);
		endcase
	endfunction

	// Mostly bounced presses whose hold and release lengths cluster around the
	// thresholds, with some bursts of plain noise.
	task automatic press_sequence(input int n);
		int stop;
		stop = sent_total + n;
		while (sent_total < stop) begin
			if ($urandom_range(99) < 20) begin
				repeat ($urandom_range(1, 12)) send_sample(1'($urandom_range(1)));
			end else begin
				repeat ($urandom_range(3)) send_sample(1'($urandom_range(1)));
				send_run(sb.pressed_lvl,
					pick_len(int'(sb.long_thr) + int'(sb.reject_thr) + 1));
				repeat ($urandom_range(3)) send_sample(1'($urandom_range(1)));
				send_run(~sb.pressed_lvl, pick_len(int'(sb.reject_thr) + 1));
			end
		end
	endtask

	initial begin
		bdsl_pkg::result_t got;
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = {short_press, long_press, button_state};
				sb.check_result(got);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_UNMAPPED, 16'h5A5A, 1'b0);
		write_reg(bdsl_pkg::CFG_PRESSED_LEVEL, 16'd0, 1'b0);
		write_reg(bdsl_pkg::CFG_REJECT_TICKS, 16'd0, 1'b0);
		write_reg(bdsl_pkg::CFG_LONG_TICKS, 16'd3, 1'b1);
		for (int i = 0; i < 19; i++) send_sample(DIRECTED[i]);

		configure(1'b1, 16'd3, 16'd15);
		press_sequence(400);
		configure(1'b0, 16'd0, 16'd0);
		press_sequence(250);

		steady = 1'b1;
		configure(1'b1, 16'd1, 16'd5);
		press_sequence(100);
		hold_req = 1'b1;
		press_sequence(200);
		steady = 1'b0;

		// The pressed level is swapped in the middle of a confirmed press.
		configure(1'b1, 16'd4, 16'd30);
		send_run(1'b1, 8);
		configure(1'b0, 16'd5, 16'd40);
		press_sequence(400);

		configure(1'b1, 16'd20, THR_TOP);
		press_sequence(250);
		configure(1'b0, 16'd2, 16'd8);
		press_sequence(300);
		send_run(1'b1, 20);

		// With both thresholds at 65534, one below their top, the press waits in leading seen.
		configure(1'b0, THR_TOP, THR_TOP);
		send_run(1'b0, 40);
		send_run(1'b1, 10);

		settle();
		repeat (10) @(posedge clk);
		$display("Sent %0d pin samples over nine register settings, thresholds up to the top.",
			sent_total);
		$display("Saw %0d short presses and %0d long presses.", sb.shorts, sb.longs);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("button_debounce_short_long_press test passed");
		end else begin
			$display("button_debounce_short_long_press test failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timed out with %0d results outstanding.", sb.pending_q.size());
		$display("button_debounce_short_long_press test failed");
		$finish;
	end

endmodule
